// ===== src/sha256_pkg.sv =====
// SHA-256 stream hasher: shared types, constants and the rotate function.
// No dependencies.

package sha256_pkg;

   localparam int unsigned DigestWords = 8;
   localparam int unsigned BlockBytes  = 64;
   localparam int unsigned Rounds      = 64;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic        load_byte;   // write req byte at fill position, count it
      logic        load_pad;    // write pad byte at pad position
      logic [7:0]  pad_byte;
      logic [5:0]  pad_pos;
      logic        comp_start;  // copy hash into working vars
      logic        comp_round;  // run one round
      logic [5:0]  round_idx;
      logic        comp_final;  // add working vars into hash
      logic        restart;     // back to initial hash, zero count and fill
   } dp_cmd_type;

   typedef struct packed {
      logic [5:0]  fill;
      logic [63:0] bit_count;
   } dp_status_type;

   typedef logic [31:0] word_type;

   localparam logic [7:0] PadMarker = 8'h80;
   localparam logic [5:0] LenPos    = 6'd56;

   localparam word_type InitHash [DigestWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type RoundConst [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

// ===== src/sha256_datapath.sv =====
// SHA-256 datapath: block buffer, message schedule, one round per cycle,
// hash and bit count. Depends on sha256_pkg.

module sha256_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  sha256_pkg::req_type       req_data,
   input  sha256_pkg::dp_cmd_type    cmd,
   input  logic [2:0]                out_idx,
   output sha256_pkg::dp_status_type status,
   output sha256_pkg::word_type      out_word
);

   // block held as sixteen big-endian words, bytes written into their lanes
   sha256_pkg::word_type block_ff [sha256_pkg::BlockBytes / 4];
   sha256_pkg::word_type sched_ff [16];
   sha256_pkg::word_type wv_ff    [8];
   sha256_pkg::word_type hash_ff  [8];
   logic [63:0]          count_ff, count_in;
   logic [5:0]           fill_ff, fill_in;

   sha256_pkg::word_type w, a2, a15, s0, s1, ch, maj, t1, t2;
   logic [3:0] ri;
   logic [5:0] wr_pos;
   logic [7:0] wr_byte;

   assign ri = cmd.round_idx[3:0];
   assign a2  = sched_ff[4'(ri - 4'd2)];
   assign a15 = sched_ff[4'(ri - 4'd15)];
   assign wr_pos  = cmd.load_byte ? fill_ff : cmd.pad_pos;
   assign wr_byte = cmd.load_byte ? req_data.data_byte : cmd.pad_byte;

   always_comb begin
      if (cmd.round_idx < 6'd16) begin
         w = block_ff[ri];
      end else begin
         w = (sha256_pkg::rotr(a2, 17) ^ sha256_pkg::rotr(a2, 19) ^ (a2 >> 10))
           + sched_ff[4'(ri - 4'd7)]
           + (sha256_pkg::rotr(a15, 7) ^ sha256_pkg::rotr(a15, 18) ^ (a15 >> 3))
           + sched_ff[ri];
      end
      s1  = sha256_pkg::rotr(wv_ff[4], 6) ^ sha256_pkg::rotr(wv_ff[4], 11)
          ^ sha256_pkg::rotr(wv_ff[4], 25);
      ch  = (wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]);
      t1  = wv_ff[7] + s1 + ch + sha256_pkg::RoundConst[cmd.round_idx] + w;
      s0  = sha256_pkg::rotr(wv_ff[0], 2) ^ sha256_pkg::rotr(wv_ff[0], 13)
          ^ sha256_pkg::rotr(wv_ff[0], 22);
      maj = (wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]);
      t2  = s0 + maj;
   end

   always_comb begin
      count_in = count_ff;
      fill_in  = fill_ff;
      if (cmd.restart) begin
         count_in = '0;
         fill_in  = '0;
      end else if (cmd.load_byte) begin
         count_in = count_ff + 64'd8;
         fill_in  = fill_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fill_ff  <= '0;
         for (int i = 0; i < 8; i++) hash_ff[i] <= sha256_pkg::InitHash[i];
      end else begin
         count_ff <= count_in;
         fill_ff  <= fill_in;
         if (cmd.restart) begin
            for (int i = 0; i < 8; i++) hash_ff[i] <= sha256_pkg::InitHash[i];
         end else if (cmd.comp_final) begin
            for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + wv_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_byte || cmd.load_pad) begin
         block_ff[wr_pos[5:2]][{2'(2'd3 - wr_pos[1:0]), 3'b000} +: 8] <= wr_byte;
      end
      if (cmd.comp_start) begin
         for (int i = 0; i < 8; i++) wv_ff[i] <= hash_ff[i];
      end else if (cmd.comp_round) begin
         sched_ff[ri] <= w;
         wv_ff[7] <= wv_ff[6];
         wv_ff[6] <= wv_ff[5];
         wv_ff[5] <= wv_ff[4];
         wv_ff[4] <= wv_ff[3] + t1;
         wv_ff[3] <= wv_ff[2];
         wv_ff[2] <= wv_ff[1];
         wv_ff[1] <= wv_ff[0];
         wv_ff[0] <= t1 + t2;
      end
   end

   assign status.fill      = fill_ff;
   assign status.bit_count = count_ff;
   assign out_word         = hash_ff[out_idx];

endmodule

// ===== src/sha256_controller.sv =====
// SHA-256 controller: request intake, padding sequence, round sequencing,
// digest readout. Depends on sha256_pkg.

module sha256_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  sha256_pkg::req_type       req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  sha256_pkg::dp_status_type status,
   output sha256_pkg::dp_cmd_type    cmd,
   output logic [2:0]                out_idx
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_BLKGO = 6'b000010,
      ST_ROUND = 6'b000100,
      ST_FINAL = 6'b001000,
      ST_PAD   = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] round_ff, round_in;
   logic [5:0] pos_ff, pos_in;           // next pad byte position
   logic       ending_ff, ending_in;     // padding in progress
   logic       marker_ff, marker_in;     // 0x80 already written
   logic       len_here_ff, len_here_in; // length goes into the block being padded
   logic       len_done_ff, len_done_in; // last compressed block held the length
   logic [2:0] idx_ff, idx_in;

   assign out_idx = idx_ff;

   always_comb begin
      state_in    = state_ff;
      round_in    = round_ff;
      pos_in      = pos_ff;
      ending_in   = ending_ff;
      marker_in   = marker_ff;
      len_here_in = len_here_ff;
      len_done_in = len_done_ff;
      idx_in      = idx_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd         = '0;
      cmd.round_idx = round_ff;
      cmd.pad_pos   = pos_ff;
      cmd.pad_byte  = 8'h00;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_byte = req_data.byte_present;
               ending_in   = req_data.end_of_message;
               marker_in   = 1'b0;
               len_here_in = 1'b0;
               len_done_in = 1'b0;
               pos_in = req_data.byte_present ? 6'(status.fill + 6'd1) : status.fill;
               if (req_data.byte_present && status.fill == 6'd63) begin
                  state_in = ST_BLKGO;
               end else if (req_data.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_BLKGO: begin
            cmd.comp_start = 1'b1;
            round_in = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.comp_round = 1'b1;
            round_in = 6'(round_ff + 6'd1);
            if (round_ff == 6'd63) state_in = ST_FINAL;
         end
         ST_FINAL: begin
            cmd.comp_final = 1'b1;
            if (!ending_ff) state_in = ST_IDLE;
            else if (len_done_ff) state_in = ST_EMIT;
            else state_in = ST_PAD;
         end
         ST_PAD: begin
            cmd.load_pad = 1'b1;
            if (!marker_ff) begin
               cmd.pad_byte = sha256_pkg::PadMarker;
               marker_in   = 1'b1;
               len_here_in = pos_ff < sha256_pkg::LenPos;
            end else if (len_here_ff && pos_ff >= sha256_pkg::LenPos) begin
               cmd.pad_byte = status.bit_count[{3'(3'd7 - pos_ff[2:0]), 3'b000} +: 8];
            end
            pos_in = 6'(pos_ff + 6'd1);
            if (pos_ff == 6'd63) begin
               // a following block always carries the length
               len_done_in = marker_ff && len_here_ff;
               len_here_in = 1'b1;
               state_in    = ST_BLKGO;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               idx_in = 3'(idx_ff + 3'd1);
               if (idx_ff == 3'd7) begin
                  cmd.restart = 1'b1;
                  ending_in   = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         round_ff    <= '0;
         pos_ff      <= '0;
         ending_ff   <= 1'b0;
         marker_ff   <= 1'b0;
         len_here_ff <= 1'b0;
         len_done_ff <= 1'b0;
         idx_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         round_ff    <= round_in;
         pos_ff      <= pos_in;
         ending_ff   <= ending_in;
         marker_ff   <= marker_in;
         len_here_ff <= len_here_in;
         len_done_ff <= len_done_in;
         idx_ff      <= idx_in;
      end
   end

endmodule

// ===== src/sha256_stream_hasher.sv =====
// SHA-256 stream hasher top level: controller plus datapath.
// Depends on sha256_pkg, sha256_controller, sha256_datapath.
//
//   channel  direction  payload              handshake
//   req      in         req_type (one byte)  req_valid / req_ready
//   rsp      out        rsp_type (one word)  rsp_valid / rsp_ready
//
// A byte request is written into the block as it is taken; the 64th byte of a
// block then runs the load, 64 rounds at one per cycle and the hash update
// before the next request is taken. An end request pads one byte per cycle
// and runs one or two blocks before the first digest word, then eight words.
// Synchronous active-high reset restores the initial hash and zero count.
// A stalled rsp holds the current word; no request is taken until all
// eight words have gone out.

module sha256_stream_hasher (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sha256_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sha256_pkg::rsp_type rsp_data
);

   sha256_pkg::dp_cmd_type    cmd;
   sha256_pkg::dp_status_type status;
   sha256_pkg::word_type      word;
   logic [2:0]                idx;

   sha256_controller u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .status, .cmd, .out_idx(idx)
   );

   sha256_datapath u_dp (
      .clock, .reset, .req_data, .cmd, .out_idx(idx), .status, .out_word(word)
   );

   assign rsp_data.digest_word = word;
   assign rsp_data.word_index  = idx;
   assign rsp_data.last_word   = (idx == 3'd7);

endmodule
